[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define IRPCD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IRPCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/irpcd_pkg.sv]
// Types and constants of the IR pulse command decoder.
package irpcd_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_START_MIN  = 3'd0;
  localparam logic [2:0] REG_START_MAX  = 3'd1;
  localparam logic [2:0] REG_ONE_MIN    = 3'd2;
  localparam logic [2:0] REG_ONE_MAX    = 3'd3;
  localparam logic [2:0] REG_ZERO_MIN   = 3'd4;
  localparam logic [2:0] REG_ZERO_MAX   = 3'd5;
  localparam logic [2:0] REG_DIR_CODES  = 3'd6;
  localparam logic [2:0] REG_TOGGLE     = 3'd7;

  // Command kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_UP     = 3'd1;
  localparam logic [2:0] KIND_DOWN   = 3'd2;
  localparam logic [2:0] KIND_RIGHT  = 3'd3;
  localparam logic [2:0] KIND_LEFT   = 3'd4;
  localparam logic [2:0] KIND_TOGGLE = 3'd5;

  // Cursor limits and reset position
  localparam logic [3:0] X_MAX   = 4'd11;
  localparam logic [2:0] Y_MAX   = 3'd7;
  localparam logic [3:0] X_RESET = 4'd4;
  localparam logic [2:0] Y_RESET = 3'd4;

  // Depth of the code queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Widest code the matcher compares
  localparam int MATCH_W = 32;

  // Output payload width, padded to whole bytes
  localparam int TDATA_W = 32;

  // Pulse classification windows
  typedef struct packed {
    logic [15:0] start_min;
    logic [15:0] start_max;
    logic [15:0] one_min;
    logic [15:0] one_max;
    logic [15:0] zero_min;
    logic [15:0] zero_max;
  } win_cfg_t;

  // Command codes to match against
  typedef struct packed {
    logic [15:0] up;
    logic [15:0] down;
    logic [15:0] right;
    logic [15:0] left;
    logic [15:0] toggle;
  } match_cfg_t;

endpackage

[rtl/irpcd_front.sv]
// Front end: classifies pulse widths and assembles codes.
module irpcd_front #(
  parameter int CODE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  irpcd_pkg::win_cfg_t        win,
  input  logic                       accept,
  input  logic [15:0]                pulse_ticks,
  output logic                       push,
  output logic [CODE_BITS-1:0]       push_code
);

  localparam int CNT_W = $clog2(CODE_BITS);

  logic                 collecting;
  logic [CNT_W-1:0]     bit_count;
  logic [CODE_BITS-1:0] code_shift;
  logic                 is_start;
  logic                 is_one;
  logic                 is_zero;
  logic                 last_bit;

  // Strict window compares
  assign is_start = (pulse_ticks > win.start_min) && (pulse_ticks < win.start_max);
  assign is_one   = (pulse_ticks > win.one_min) && (pulse_ticks < win.one_max);
  assign is_zero  = (pulse_ticks > win.zero_min) && (pulse_ticks < win.zero_max);
  assign last_bit = (bit_count == CNT_W'(CODE_BITS - 1));

  // Completed code goes to the queue
  assign push      = accept && !is_start && (is_one || is_zero) && collecting && last_bit;
  assign push_code = {code_shift[CODE_BITS-2:0], is_one};

  // Collection state
  always_ff @(posedge clk) begin
    if (rst) begin
      collecting <= 1'b0;
      bit_count  <= '0;
      code_shift <= '0;
    end else if (accept) begin
      priority if (is_start) begin
        collecting <= 1'b1;
        bit_count  <= '0;
        code_shift <= '0;
      end else if (is_one || is_zero) begin
        if (collecting) begin
          if (last_bit) begin
            collecting <= 1'b0;
            bit_count  <= '0;
            code_shift <= '0;
          end else begin
            bit_count  <= bit_count + 1'b1;
            code_shift <= {code_shift[CODE_BITS-2:0], is_one};
          end
        end
      end else begin
        collecting <= 1'b0;
        bit_count  <= '0;
        code_shift <= '0;
      end
    end
  end

endmodule

[rtl/irpcd_fifo.sv]
// Short queue of completed codes between front and back.
module irpcd_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/irpcd_back.sv]
// Back end: matches codes, moves the cursor and holds the result register.
module irpcd_back #(
  parameter int CODE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  irpcd_pkg::match_cfg_t              codes,
  input  logic                               code_valid,
  input  logic [CODE_BITS-1:0]               code,
  output logic                               code_pop,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [irpcd_pkg::TDATA_W-1:0]      m_tdata
);

  logic [irpcd_pkg::MATCH_W-1:0] code_wide;
  logic [2:0]  kind;
  logic [3:0]  pos_x;
  logic [2:0]  pos_y;
  logic        color_flag;
  logic [3:0]  pos_x_next;
  logic [2:0]  pos_y_next;
  logic        color_flag_next;
  logic [15:0] out_code;
  logic [2:0]  out_kind;

  assign code_wide = irpcd_pkg::MATCH_W'(code);
  assign code_pop  = code_valid && (!m_tvalid || m_tready);

  // Priority match and cursor update
  always_comb begin
    kind            = irpcd_pkg::KIND_NONE;
    pos_x_next      = pos_x;
    pos_y_next      = pos_y;
    color_flag_next = color_flag;
    priority if (code_wide == irpcd_pkg::MATCH_W'(codes.up)) begin
      kind = irpcd_pkg::KIND_UP;
      if (pos_y != 3'd0) pos_y_next = pos_y - 3'd1;
    end else if (code_wide == irpcd_pkg::MATCH_W'(codes.down)) begin
      kind = irpcd_pkg::KIND_DOWN;
      if (pos_y < irpcd_pkg::Y_MAX) pos_y_next = pos_y + 3'd1;
    end else if (code_wide == irpcd_pkg::MATCH_W'(codes.right)) begin
      kind = irpcd_pkg::KIND_RIGHT;
      if (pos_x < irpcd_pkg::X_MAX) pos_x_next = pos_x + 4'd1;
    end else if (code_wide == irpcd_pkg::MATCH_W'(codes.left)) begin
      kind = irpcd_pkg::KIND_LEFT;
      if (pos_x != 4'd0) pos_x_next = pos_x - 4'd1;
    end else if (code_wide == irpcd_pkg::MATCH_W'(codes.toggle)) begin
      kind            = irpcd_pkg::KIND_TOGGLE;
      color_flag_next = ~color_flag;
    end else begin
      kind = irpcd_pkg::KIND_NONE;
    end
  end

  // Cursor state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= irpcd_pkg::X_RESET;
      pos_y      <= irpcd_pkg::Y_RESET;
      color_flag <= 1'b1;
      m_tvalid   <= 1'b0;
    end else begin
      if (code_pop) begin
        pos_x      <= pos_x_next;
        pos_y      <= pos_y_next;
        color_flag <= color_flag_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (code_pop) begin
      out_code <= code_wide[15:0];
      out_kind <= kind;
    end
  end

  assign m_tdata = {5'd0, color_flag, pos_y, pos_x, out_kind, out_code};

endmodule

[rtl/ir_pulse_command_decoder.sv]
// Top level of the IR pulse command decoder.
//
//   channel | handshake                  | payload
//   s_      | s_tvalid / s_tready        | s_tdata: pulse_ticks
//   m_      | m_tvalid / m_tready        | m_tdata: code, kind, x, y, color
//   cfg_    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One pulse per cycle is taken; s_tready drops only while the 4-entry code
// queue between the two ends is full. A completed code is pushed into it,
// popped by the back end and latched onto m_tdata. The front end holds the
// collection state, the back end the cursor. Reset clears all windows and
// codes, sets the cursor to (4,4) and color on. cfg_ready is always high.
module ir_pulse_command_decoder #(
  parameter int CODE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // pulse_ticks [15:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // command_code [15:0], command_kind [18:16], cursor_x [22:19],
  // cursor_y [25:23], color_on [26], zero [31:27]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  irpcd_pkg::win_cfg_t   win;
  irpcd_pkg::match_cfg_t codes;
  logic                  accept;
  logic                  push;
  logic [CODE_BITS-1:0]  push_code;
  logic                  pop;
  logic [CODE_BITS-1:0]  pop_code;
  logic                  q_empty;
  logic                  q_full;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win   <= '0;
      codes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        irpcd_pkg::REG_START_MIN: win.start_min <= cfg_data[15:0];
        irpcd_pkg::REG_START_MAX: win.start_max <= cfg_data[15:0];
        irpcd_pkg::REG_ONE_MIN:   win.one_min   <= cfg_data[15:0];
        irpcd_pkg::REG_ONE_MAX:   win.one_max   <= cfg_data[15:0];
        irpcd_pkg::REG_ZERO_MIN:  win.zero_min  <= cfg_data[15:0];
        irpcd_pkg::REG_ZERO_MAX:  win.zero_max  <= cfg_data[15:0];
        irpcd_pkg::REG_DIR_CODES: begin
          codes.up    <= cfg_data[15:0];
          codes.down  <= cfg_data[31:16];
          codes.right <= cfg_data[47:32];
          codes.left  <= cfg_data[63:48];
        end
        irpcd_pkg::REG_TOGGLE:    codes.toggle  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  irpcd_front #(
    .CODE_BITS(CODE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .win        (win),
    .accept     (accept),
    .pulse_ticks(s_tdata),
    .push       (push),
    .push_code  (push_code)
  );

  irpcd_fifo #(
    .WIDTH(CODE_BITS),
    .DEPTH(irpcd_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_code),
    .pop      (pop),
    .pop_data (pop_code),
    .empty    (q_empty),
    .full     (q_full)
  );

  irpcd_back #(
    .CODE_BITS(CODE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .codes     (codes),
    .code_valid(!q_empty),
    .code      (pop_code),
    .code_pop  (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

[rtl/irpcd_checker.sv]
// Port-level checks of the IR pulse command decoder, bound to the top level.
`include "assert_macros.svh"

module irpcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [63:0] cfg_data
);

  // A stalled result stays offered
  `IRPCD_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  // Cursor column stays within the grid
  `IRPCD_ASSERT(a_x_range, clk, rst, m_tvalid |-> (m_tdata[22:19] <= 4'd11), "cursor_x out of range")
  // Only defined command kinds are reported
  `IRPCD_ASSERT(a_kind_range, clk, rst, m_tvalid |-> (m_tdata[18:16] <= 3'd5), "bad command_kind")
  // No result right after reset
  `IRPCD_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !m_tvalid, "result valid after reset")

endmodule

bind ir_pulse_command_decoder irpcd_checker u_irpcd_checker (.*);
